>>> rtl/matrix4x4_chain_multiply_macros.svh
// Assertion macros shared by the matrix chain multiplier RTL
`ifndef MATRIX4X4_CHAIN_MULTIPLY_MACROS_SVH
`define MATRIX4X4_CHAIN_MULTIPLY_MACROS_SVH

// same-cycle implication
`define MCM_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcm assertion failed");

// next-cycle implication
`define MCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcm assertion failed");

`endif

>>> rtl/mcm_pkg.sv
// Types, constants and helpers for the matrix chain multiplier
`default_nettype none

package mcm_pkg;

  localparam int DIM       = 4;
  localparam int ELEMS     = DIM * DIM;
  localparam int IDX_W     = $clog2(ELEMS);
  localparam int HALF_W    = IDX_W / 2;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int STEP_W    = 3 * HALF_W;
  localparam int FRAC_BITS = 16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // read port request, product and incoming stores
  typedef struct packed {
    logic en;
    logic bank;
    logic ident;
    idx_t p_idx;
    idx_t m_idx;
  } rd_req_t;

  // incoming element write
  typedef struct packed {
    logic  en;
    idx_t  idx;
    data_t data;
  } ld_req_t;

  // tag travelling with one MAC operand pair
  typedef struct packed {
    logic en;
    logic first;
    logic last;
    logic fin;
    idx_t dest;
  } mac_tag_t;

  // product element write-back
  typedef struct packed {
    logic  en;
    logic  fin;
    idx_t  idx;
    data_t data;
  } wr_req_t;

  function automatic data_t identity_elem(idx_t idx);
    data_t one;
    one = data_t'(1) << FRAC_BITS;
    return (idx[IDX_W-1:HALF_W] == idx[HALF_W-1:0]) ? one : '0;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mcm_mem.sv
// Product store (two banks) and incoming matrix store, registered reads
`default_nettype none

module mcm_mem (
  input  logic            clk,
  input  mcm_pkg::rd_req_t rd,
  input  mcm_pkg::ld_req_t ld,
  input  mcm_pkg::wr_req_t wr,
  output mcm_pkg::data_t   p_q,
  output mcm_pkg::data_t   m_q
);
  import mcm_pkg::*;

  data_t pmem [2*ELEMS];
  data_t mmem [ELEMS];

  // results go to the bank not being read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pmem[{~rd.bank, wr.idx}] <= wr.data;
    end
    if (ld.en) begin
      mmem[ld.idx] <= ld.data;
    end
    if (rd.en) begin
      p_q <= rd.ident ? identity_elem(rd.p_idx) : pmem[{rd.bank, rd.p_idx}];
      m_q <= mmem[rd.m_idx];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mcm_mac.sv
// Multiply-accumulate pipeline with floor shift and saturation
`default_nettype none

module mcm_mac (
  input  logic             clk,
  input  logic             rst,
  input  mcm_pkg::mac_tag_t tag_in,
  input  mcm_pkg::data_t    p_q,
  input  mcm_pkg::data_t    m_q,
  output mcm_pkg::wr_req_t  wr
);
  import mcm_pkg::*;

  mac_tag_t tag1, tag2, tag3;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    hi;
  data_t                    sat;

  always_comb begin
    shifted = acc >>> FRAC_BITS;
    hi      = shifted[ACC_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      sat = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tag_in;
    tag2 <= tag1;
    tag3 <= tag2;
    prod <= PROD_W'(p_q) * PROD_W'(m_q);
    if (tag2.en) begin
      acc <= tag2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    wr.en   <= tag3.en && tag3.last;
    wr.fin  <= tag3.fin;
    wr.idx  <= tag3.dest;
    wr.data <= sat;
    if (rst) begin
      tag1.en <= 1'b0;
      tag2.en <= 1'b0;
      tag3.en <= 1'b0;
      wr.en   <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/matrix4x4_chain_multiply.sv
// Top level: 4x4 fixed-point matrix chain multiplier, sequencer and result port
//
//   channel   handshake               payload
//   input     start, accepted !busy   cmd, element_value
//   result    done, once per word     product_value, element_index,
//                                     last_element, partial_error
//
// A load is accepted while busy is low; the sixteenth load of a matrix then
// keeps busy high for 64 MACs through the one multiplier, plus pipeline drain.
// A finish emits 16 words back to back, the first once the product store's read
// is registered; busy stays high until the last word appears. A finish after a
// partial matrix gives a single error word the next cycle and leaves busy low.
// Reset (rst, synchronous) sets the product to identity and the count to 0.
// The receiver cannot stall; words are never held.
`default_nettype none
`include "matrix4x4_chain_multiply_macros.svh"

module matrix4x4_chain_multiply (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic           cmd,
  input  mcm_pkg::data_t element_value,
  output logic           done,
  output mcm_pkg::data_t product_value,
  output mcm_pkg::idx_t  element_index,
  output logic           last_element,
  output logic           partial_error
);
  import mcm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DRAIN, S_EMIT} state_t;

  state_t              state;
  idx_t                count;
  logic [STEP_W-1:0]   step;
  idx_t                emit_cnt;
  logic                bank;
  logic                ident;
  logic                emit_v;
  logic                emit_err;
  logic                emit_last;
  idx_t                emit_idx;

  logic     accept;
  rd_req_t  rd;
  ld_req_t  ld;
  mac_tag_t tag;
  wr_req_t  wr;
  data_t    p_q;
  data_t    m_q;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // step = {row, col, k}
  always_comb begin
    ld.en     = accept && (cmd == CMD_LOAD);
    ld.idx    = count;
    ld.data   = element_value;
    rd.bank   = bank;
    rd.ident  = ident;
    tag.first = (step[HALF_W-1:0] == '0);
    tag.last  = (&step[HALF_W-1:0]);
    tag.fin   = (&step);
    tag.dest  = step[STEP_W-1:HALF_W];
    unique case (state)
      S_MUL: begin
        rd.en    = 1'b1;
        rd.p_idx = {step[STEP_W-1:2*HALF_W], step[HALF_W-1:0]};
        rd.m_idx = {step[HALF_W-1:0], step[2*HALF_W-1:HALF_W]};
        tag.en   = 1'b1;
      end
      S_EMIT: begin
        rd.en    = 1'b1;
        rd.p_idx = emit_cnt;
        rd.m_idx = emit_cnt;
        tag.en   = 1'b0;
      end
      default: begin
        rd.en    = 1'b0;
        rd.p_idx = emit_cnt;
        rd.m_idx = emit_cnt;
        tag.en   = 1'b0;
      end
    endcase
  end

  mcm_mem u_mem (
    .clk (clk),
    .rd  (rd),
    .ld  (ld),
    .wr  (wr),
    .p_q (p_q),
    .m_q (m_q)
  );

  mcm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag),
    .p_q    (p_q),
    .m_q    (m_q),
    .wr     (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      emit_cnt  <= '0;
      bank      <= 1'b0;
      ident     <= 1'b1;
      emit_v    <= 1'b0;
      emit_err  <= 1'b0;
      emit_last <= 1'b0;
      emit_idx  <= '0;
    end else begin
      emit_v <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_LOAD) begin
              count <= count + 1'b1;
              if (count == idx_t'(ELEMS - 1)) begin
                state <= S_MUL;
                step  <= '0;
              end
            end else if (count != '0) begin
              emit_v    <= 1'b1;
              emit_err  <= 1'b1;
              emit_last <= 1'b1;
              emit_idx  <= '0;
              count     <= '0;
              ident     <= 1'b1;
            end else begin
              state    <= S_EMIT;
              emit_cnt <= '0;
            end
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (&step) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (wr.en && wr.fin) begin
            state <= S_IDLE;
            bank  <= ~bank;
            ident <= 1'b0;
          end
        end
        S_EMIT: begin
          emit_v    <= 1'b1;
          emit_err  <= 1'b0;
          emit_idx  <= emit_cnt;
          emit_last <= &emit_cnt;
          emit_cnt  <= emit_cnt + 1'b1;
          if (&emit_cnt) begin
            state <= S_IDLE;
            ident <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done          = emit_v;
  assign product_value = emit_err ? '0 : p_q;
  assign element_index = emit_idx;
  assign last_element  = emit_last;
  assign partial_error = emit_err;

  `MCM_ASSERT(a_quiet_in_mul, clk, rst, (state == S_MUL || state == S_DRAIN), !done)
  `MCM_ASSERT(a_wr_in_mul, clk, rst, wr.en, (state == S_MUL || state == S_DRAIN))
  `MCM_ASSERT(a_fin_in_drain, clk, rst, (wr.en && wr.fin), (state == S_DRAIN))
  `MCM_ASSERT_NEXT(a_mul_on_full, clk, rst, (ld.en && (&count)), (state == S_MUL))

endmodule

`default_nettype wire

>>> tb/chain_product_checker.sv
// Checker for the matrix chain multiplier: predicts result words and compares them
module chain_product_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  logic           cmd,
  input  mcm_pkg::data_t element_value,
  input  logic           done,
  input  mcm_pkg::data_t product_value,
  input  mcm_pkg::idx_t  element_index,
  input  logic           last_element,
  input  logic           partial_error,
  output int             failures,
  output int             words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import mcm_pkg::*;

  typedef struct packed {
    data_t value;
    idx_t  index;
    logic  last;
    logic  part_err;
  } out_word_t;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  data_t     chain_prod [ELEMS];
  data_t     load_buf [ELEMS];
  idx_t      load_count;
  out_word_t expected_words [$];
  int        fail_tally = 0;

  task automatic reset_product();
    for (int k = 0; k < ELEMS; k++) begin
      chain_prod[k] = (k / DIM == k % DIM) ? data_t'(1) <<< FRAC_BITS : '0;
    end
  endtask

  // exact four-term sum, floor shift, then clamp to 32 bits
  function automatic data_t dot_row_col(int row, int col);
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      acc += chain_prod[row * DIM + k] * load_buf[k * DIM + col];
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > SAT_HI) return 32'sh7FFF_FFFF;
    if (scaled < SAT_LO) return 32'sh8000_0000;
    return data_t'(scaled[31:0]);
  endfunction

  task automatic fold_in();
    data_t next_prod [ELEMS];
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        next_prod[r * DIM + c] = dot_row_col(r, c);
      end
    end
    chain_prod = next_prod;
  endtask

  task automatic take_item(logic op, data_t value);
    out_word_t w;
    if (op == CMD_LOAD) begin
      load_buf[load_count] = value;
      load_count = load_count + 1'b1;
      if (load_count == '0) fold_in();
    end else if (load_count != '0) begin
      w = '{value: '0, index: '0, last: 1'b1, part_err: 1'b1};
      expected_words.push_back(w);
      load_count = '0;
      reset_product();
    end else begin
      for (int k = 0; k < ELEMS; k++) begin
        w = '{value: chain_prod[k], index: idx_t'(k), last: (k == ELEMS - 1),
              part_err: 1'b0};
        expected_words.push_back(w);
      end
      reset_product();
    end
  endtask

  task automatic check_word();
    out_word_t w;
    if (expected_words.size() == 0) begin
      $error("unexpected word: product_value %08h, element_index %0d",
             product_value, element_index);
      fail_tally++;
    end else begin
      w = expected_words.pop_front();
      if (product_value !== w.value) begin
        $error("product_value: expected %08h, got %08h", w.value, product_value);
        fail_tally++;
      end
      if (element_index !== w.index) begin
        $error("element_index: expected %0d, got %0d", w.index, element_index);
        fail_tally++;
      end
      if (last_element !== w.last) begin
        $error("last_element: expected %0b, got %0b", w.last, last_element);
        fail_tally++;
      end
      if (partial_error !== w.part_err) begin
        $error("partial_error: expected %0b, got %0b", w.part_err, partial_error);
        fail_tally++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_product();
      load_count = '0;
      expected_words.delete();
    end else begin
      if (done === 1'b1) check_word();
      if (start === 1'b1 && busy === 1'b0) take_item(cmd, element_value);
    end
    failures  <= fail_tally;
    words_due <= expected_words.size();
  end

endmodule

>>> tb/testbench.sv
// Testbench top: clock, reset, stimulus, watchdog and verdict for the chain multiplier
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcm_pkg::*;

  localparam int SEND_TOTAL  = 460;
  localparam int CALM_TAIL   = 60;
  localparam int STALL_LIMIT = 1000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  cmd = CMD_LOAD;
  data_t element_value = '0;
  logic  busy;
  logic  done;
  data_t product_value;
  idx_t  element_index;
  logic  last_element;
  logic  partial_error;
  int    failures;
  int    words_due;

  int          sent = 0;
  int          stall_cycles = 0;
  int unsigned gap_odds = 0;

  data_t corner_vals [ELEMS] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'h7FFF_0000,
    32'h8000_FFFF, 32'h0123_4567, 32'hFEDC_BA98, 32'h0002_0000
  };

  always #2 clk = ~clk;

  matrix4x4_chain_multiply dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .element_value (element_value),
    .done          (done),
    .product_value (product_value),
    .element_index (element_index),
    .last_element  (last_element),
    .partial_error (partial_error)
  );

  chain_product_checker product_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .element_value (element_value),
    .done          (done),
    .product_value (product_value),
    .element_index (element_index),
    .last_element  (last_element),
    .partial_error (partial_error),
    .failures      (failures),
    .words_due     (words_due)
  );

  // called just after a rising edge; returns at the edge that accepts the word
  task automatic push_word(logic op, data_t value);
    if (gap_odds != 0 && sent < SEND_TOTAL - CALM_TAIL &&
        $urandom_range(1, gap_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start         <= 1'b1;
    cmd           <= op;
    element_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic pause_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  function automatic data_t pick_element(bit tame);
    int unsigned sel;
    data_t       v;
    sel = tame ? $urandom_range(6, 9) : $urandom_range(0, 9);
    case (sel)
      0, 1, 2: v = data_t'($urandom);
      3: begin
        case ($urandom_range(0, 5))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = -32'sd1;
          4:       v = 32'sd1;
          default: v = 32'sh0001_0000;
        endcase
      end
      4, 5:    v = data_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      6, 7, 8: v = data_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: begin
        case ($urandom_range(0, 2))
          0:       v = 32'sh0001_0000;
          1:       v = -32'sh0001_0000;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic push_loads(int count, bit tame);
    for (int k = 0; k < count; k++) push_word(CMD_LOAD, pick_element(tame));
  endtask

  initial begin
    int unsigned pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty chain, short partial matrix, corner-value matrix, empty again
    push_word(CMD_FINISH, data_t'($urandom));
    push_word(CMD_LOAD, 32'sh7FFF_FFFF);
    push_word(CMD_FINISH, '0);
    foreach (corner_vals[k]) push_word(CMD_LOAD, corner_vals[k]);
    push_word(CMD_FINISH, 32'shFFFF_FFFF);
    push_word(CMD_FINISH, data_t'($urandom));
    pause_for_results();

    while (sent < SEND_TOTAL) begin
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        repeat ($urandom_range(0, 3)) push_loads(ELEMS, $urandom_range(0, 2) != 0);
        push_word(CMD_FINISH, data_t'($urandom));
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) == 1) push_loads(ELEMS, 1'b1);
        push_loads($urandom_range(1, ELEMS - 1), $urandom_range(0, 1) != 0);
        push_word(CMD_FINISH, data_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_word($urandom_range(0, 1) ? CMD_FINISH : CMD_LOAD, pick_element(1'b0));
        end
      end
      if ($urandom_range(0, 11) == 0) pause_for_results();
    end

    pause_for_results();
    repeat (80) @(posedge clk);
    if (failures == 0 && words_due == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // ends the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT - 1) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
